// File: hw/rtl/twsl_pkg.sv
// Shared types, codes and constants of the twist slew and speed limiter.
package twsl_pkg;

    // Field widths.
    localparam int VelW    = 24;
    localparam int TimeW   = 32;
    localparam int PeriodW = 16;
    localparam int DtW     = 14;
    localparam int CfgW    = 26;
    localparam int CfgIdxW = 3;
    localparam int LimW    = 23;
    localparam int ProdW   = 48;
    localparam int SumW    = 50;
    localparam int RootW   = 25;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_HOLD      = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_WATCHDOG  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_LIN_SPEED = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_LIN_ACCEL = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_ANG_SPEED = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_ANG_ACCEL = 3'd5;

    // Configuration reset values.
    localparam logic [25:0]     RST_HOLD      = 26'd0;
    localparam logic [23:0]     RST_WATCHDOG  = 24'd100000;
    localparam logic [LimW-1:0] RST_LIN_SPEED = 23'd6554;
    localparam logic [LimW-1:0] RST_LIN_ACCEL = 23'd65536;
    localparam logic [LimW-1:0] RST_ANG_SPEED = 23'd32768;
    localparam logic [LimW-1:0] RST_ANG_ACCEL = 23'd65536;

    // Tick period clamp and step rounding (microseconds to seconds).
    localparam logic [DtW-1:0] DT_MIN     = 14'd100;
    localparam logic [DtW-1:0] DT_MAX     = 14'd10000;
    localparam logic [19:0]    STEP_ROUND = 20'd500000;

    // Division by one million: drop the factor 2^6 by a shift, then multiply
    // by the reciprocal of 15625 scaled by 2^45, which is exact for any
    // dividend below 2^31.
    localparam int             STEP_PRE   = 6;
    localparam int             STEP_SHIFT = 45;
    localparam logic [31:0]    STEP_RECIP = 32'd2251799814;

    // Item kinds.
    localparam logic FUNC_TARGET = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_ARM   = 2'd0,
        ST_HOLD  = 2'd1,
        ST_NOTGT = 2'd2,
        ST_TRACK = 2'd3
    } t_status;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_ARM,
        OP_ZERO,
        OP_DROP,
        OP_MUL_STEP,
        OP_DIV_LD_STEP,
        OP_DIV_ITER,
        OP_LIM_STEP,
        OP_LOAD_DELTA,
        OP_LOAD_CMD,
        OP_MUL_SQ,
        OP_ACC,
        OP_MUL_LL,
        OP_SQRT_LD,
        OP_SQRT_ITER,
        OP_MUL_SC,
        OP_DIV_LD_SC,
        OP_WR_SC,
        OP_ADD_CMD,
        OP_STORE_CMD,
        OP_OUT
    } t_op;

    // Command from controller to datapath.
    typedef struct packed {
        t_op         op;
        logic        k;      // 0 linear, 1 angular
        logic [1:0]  idx;    // component index
        t_status     status;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic is_tick;
        logic armed;
        logic in_hold;
        logic fresh;
        logic gt;
        logic div_done;
        logic sqrt_done;
    } t_stat;

    // Input payload.
    typedef struct packed {
        logic                      func;
        logic [TimeW-1:0]          time_us;
        logic [PeriodW-1:0]        period_us;
        logic signed [VelW-1:0]    lin_x;
        logic signed [VelW-1:0]    lin_y;
        logic signed [VelW-1:0]    lin_z;
        logic signed [VelW-1:0]    ang_x;
        logic signed [VelW-1:0]    ang_y;
        logic signed [VelW-1:0]    ang_z;
    } t_in_item;

endpackage

// File: hw/rtl/twsl_in_if.sv
// Input channel of the limiter: target and tick transactions.
interface twsl_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [31:0]        time_us;
    logic [15:0]        period_us;
    logic signed [23:0] lin_x;
    logic signed [23:0] lin_y;
    logic signed [23:0] lin_z;
    logic signed [23:0] ang_x;
    logic signed [23:0] ang_y;
    logic signed [23:0] ang_z;

    modport source (output valid, func, time_us, period_us,
                    output lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, input ready);
    modport sink (input valid, func, time_us, period_us,
                  input lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, output ready);
endinterface

// File: hw/rtl/twsl_out_if.sv
// Output channel of the limiter: one result transaction per tick.
interface twsl_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [23:0] cmd_lin_x;
    logic signed [23:0] cmd_lin_y;
    logic signed [23:0] cmd_lin_z;
    logic signed [23:0] cmd_ang_x;
    logic signed [23:0] cmd_ang_y;
    logic signed [23:0] cmd_ang_z;

    modport source (output valid, status, cmd_lin_x, cmd_lin_y, cmd_lin_z,
                    output cmd_ang_x, cmd_ang_y, cmd_ang_z, input ready);
    modport sink (input valid, status, cmd_lin_x, cmd_lin_y, cmd_lin_z,
                  input cmd_ang_x, cmd_ang_y, cmd_ang_z, output ready);
endinterface

// File: hw/rtl/twsl_ctrl.sv
// Sequencer of the limiter: walks each tick through the datapath operations.
module twsl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    input  twsl_pkg::t_stat i_stat,
    output twsl_pkg::t_cmd  o_cmd
);
    import twsl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DECIDE, S_MULSTEP, S_DIVLD, S_LIMSTEP, S_LOADD,
        S_SQ, S_ACC, S_LL, S_CMP, S_SQLD, S_SQRT, S_SCMUL, S_SCLD, S_DIVSC,
        S_SCWR, S_AFTER, S_LDSPD, S_OUT
    } t_state;

    t_state     r_state;
    logic       r_k;
    logic       r_pass;
    logic [1:0] r_idx;
    t_status    r_status;
    logic       r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Operation decode for the current step.
    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = OP_NOP;
        o_cmd.k      = r_k;
        o_cmd.idx    = r_idx;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE:    o_cmd.op = i_in_valid ? OP_CAPTURE : OP_NOP;
            S_DECIDE: begin
                if (!i_stat.is_tick) begin
                    o_cmd.op = OP_NOP;
                end else if (!i_stat.armed) begin
                    o_cmd.op = OP_ARM;
                end else if (i_stat.in_hold) begin
                    o_cmd.op = OP_ZERO;
                end else if (!i_stat.fresh) begin
                    o_cmd.op = OP_DROP;
                end
            end
            S_MULSTEP: o_cmd.op = OP_MUL_STEP;
            S_DIVLD:   o_cmd.op = OP_DIV_LD_STEP;
            S_LIMSTEP: o_cmd.op = OP_LIM_STEP;
            S_LOADD:   o_cmd.op = OP_LOAD_DELTA;
            S_SQ:      o_cmd.op = OP_MUL_SQ;
            S_ACC:     o_cmd.op = OP_ACC;
            S_LL:      o_cmd.op = OP_MUL_LL;
            S_SQLD:    o_cmd.op = OP_SQRT_LD;
            S_SQRT:    o_cmd.op = i_stat.sqrt_done ? OP_NOP : OP_SQRT_ITER;
            S_SCMUL:   o_cmd.op = OP_MUL_SC;
            S_SCLD:    o_cmd.op = OP_DIV_LD_SC;
            S_DIVSC:   o_cmd.op = i_stat.div_done ? OP_NOP : OP_DIV_ITER;
            S_SCWR:    o_cmd.op = OP_WR_SC;
            S_AFTER:   o_cmd.op = r_pass ? OP_STORE_CMD : OP_ADD_CMD;
            S_LDSPD:   o_cmd.op = OP_LOAD_CMD;
            S_OUT:     o_cmd.op = (!r_out_valid || i_out_ready) ? OP_OUT : OP_NOP;
            default:   o_cmd.op = OP_NOP;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= 1'b0;
            r_pass      <= 1'b0;
            r_idx       <= 2'd0;
            r_status    <= ST_ARM;
            r_out_valid <= 1'b0;
        end else begin
            // The result transaction leaves the output register unless a new one loads.
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_k    <= 1'b0;
                    r_pass <= 1'b0;
                    if (!i_stat.is_tick) begin
                        r_state <= S_IDLE;
                    end else if (!i_stat.armed) begin
                        r_status <= ST_ARM;
                        r_state  <= S_OUT;
                    end else if (i_stat.in_hold) begin
                        r_status <= ST_HOLD;
                        r_state  <= S_OUT;
                    end else if (!i_stat.fresh) begin
                        r_status <= ST_NOTGT;
                        r_state  <= S_OUT;
                    end else begin
                        r_status <= ST_TRACK;
                        r_state  <= S_MULSTEP;
                    end
                end
                S_MULSTEP: r_state <= S_DIVLD;
                S_DIVLD:   r_state <= S_LIMSTEP;
                S_LIMSTEP: r_state <= S_LOADD;
                S_LOADD: begin
                    r_pass  <= 1'b0;
                    r_idx   <= 2'd0;
                    r_state <= S_SQ;
                end
                S_SQ:  r_state <= S_ACC;
                S_ACC: begin
                    if (r_idx == 2'd2) begin
                        r_state <= S_LL;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_SQ;
                    end
                end
                S_LL:  r_state <= S_CMP;
                S_CMP: r_state <= i_stat.gt ? S_SQLD : S_AFTER;
                S_SQLD: r_state <= S_SQRT;
                S_SQRT: begin
                    if (i_stat.sqrt_done) begin
                        r_idx   <= 2'd0;
                        r_state <= S_SCMUL;
                    end
                end
                S_SCMUL: r_state <= S_SCLD;
                S_SCLD:  r_state <= S_DIVSC;
                S_DIVSC: begin
                    if (i_stat.div_done) begin
                        r_state <= S_SCWR;
                    end
                end
                S_SCWR: begin
                    if (r_idx == 2'd2) begin
                        r_state <= S_AFTER;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_SCMUL;
                    end
                end
                S_AFTER: begin
                    if (!r_pass) begin
                        r_state <= S_LDSPD;
                    end else if (!r_k) begin
                        r_k     <= 1'b1;
                        r_state <= S_MULSTEP;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_LDSPD: begin
                    r_pass  <= 1'b1;
                    r_idx   <= 2'd0;
                    r_state <= S_SQ;
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A loaded result shows as valid in the next cycle.
    a_out_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT) |=> r_out_valid)
        else $error("result register loaded but not valid");

    // The divider is never stepped past its last bit.
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_DIV_ITER) |-> !i_stat.div_done)
        else $error("divider stepped after completion");

    // The component index stays within a 3-vector.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd3)
        else $error("component index out of range");

    // Only one transaction is taken before its work starts.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transaction taken while busy");

endmodule

// File: hw/rtl/twsl_dp.sv
// Datapath of the limiter: state, configuration, multiplier, divider, root unit.
module twsl_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_idx,
    input  logic [25:0]                 i_cfg_data,
    input  twsl_pkg::t_in_item          i_item,
    input  twsl_pkg::t_cmd              i_cmd,
    output twsl_pkg::t_stat             o_stat,
    output logic [1:0]                  o_status,
    output logic signed [23:0]          o_cmd_vel [6]
);
    import twsl_pkg::*;

    // Configuration.
    logic [25:0]     r_hold;
    logic [23:0]     r_watchdog;
    logic [LimW-1:0] r_lin_speed, r_lin_accel, r_ang_speed, r_ang_accel;

    // Block state.
    logic                   r_armed;
    logic                   r_present;
    logic                   r_is_tick;
    logic [TimeW-1:0]       r_act;
    logic [TimeW-1:0]       r_ttime;
    logic [TimeW-1:0]       r_time;
    logic [DtW-1:0]         r_dt;
    logic signed [VelW-1:0] r_tgt [6];
    logic signed [VelW-1:0] r_cmd [6];

    // Working registers.
    logic signed [VelW:0]   r_v [3];
    logic [LimW-1:0]        r_lim;
    logic [ProdW-1:0]       r_p;
    logic [SumW-1:0]        r_s;

    // Divider.
    logic [ProdW-1:0]       r_dnum;
    logic [RootW-1:0]       r_drem;
    logic [RootW-1:0]       r_dden;
    logic [5:0]             r_dcnt;

    // Square root.
    logic [SumW-1:0]        r_sx;
    logic [RootW-1:0]       r_root;
    logic [RootW:0]         r_srem;
    logic [4:0]             r_scnt;

    // Result register.
    logic [1:0]             r_out_status;
    logic signed [VelW-1:0] r_out [6];

    logic signed [VelW:0]   vsel, vneg;
    logic [VelW-1:0]        mag;
    logic [23:0]            mul_a, mul_b;
    logic [LimW-1:0]        accel_k, speed_k;
    logic [RootW:0]         d_t, d_diff;
    logic                   d_ge;
    logic [RootW+2:0]       s_t, s_trial, s_diff;
    logic                   s_ge;
    logic [RootW-1:0]       root_ceil;
    logic [DtW-1:0]         dt_clamped;
    logic [TimeW-1:0]       act_age, tgt_age;
    logic [VelW-1:0]        q24;
    logic [62:0]            step_prod;

    assign accel_k = i_cmd.k ? r_ang_accel : r_lin_accel;
    assign speed_k = i_cmd.k ? r_ang_speed : r_lin_speed;

    // Step size: the pre-shifted dividend times the reciprocal of 15625.
    assign step_prod = r_dnum[30:0] * STEP_RECIP;

    // Magnitude of the selected working component.
    always_comb begin
        vsel = r_v[i_cmd.idx];
        vneg = -vsel;
        mag  = vsel[VelW] ? vneg[VelW-1:0] : vsel[VelW-1:0];
    end

    // Operand selection of the shared multiplier.
    always_comb begin
        case (i_cmd.op)
            OP_MUL_STEP: begin mul_a = {1'b0, accel_k}; mul_b = {10'd0, r_dt}; end
            OP_MUL_SQ:   begin mul_a = mag;             mul_b = mag;           end
            OP_MUL_LL:   begin mul_a = {1'b0, r_lim};   mul_b = {1'b0, r_lim}; end
            OP_MUL_SC:   begin mul_a = mag;             mul_b = {1'b0, r_lim}; end
            default:     begin mul_a = '0;              mul_b = '0;            end
        endcase
    end

    // One restoring division step and one root digit.
    always_comb begin
        d_t       = {r_drem, r_dnum[ProdW-1]};
        d_ge      = d_t >= {1'b0, r_dden};
        d_diff    = d_t - {1'b0, r_dden};
        s_t       = {r_srem, r_sx[SumW-1:SumW-2]};
        s_trial   = {1'b0, r_root, 2'b01};
        s_ge      = s_t >= s_trial;
        s_diff    = s_t - s_trial;
        root_ceil = r_root + RootW'(r_srem != '0);
        q24       = r_dnum[VelW-1:0];
    end

    // Period clamp and ages modulo 2^32.
    always_comb begin
        if (i_item.period_us < PeriodW'(DT_MIN)) begin
            dt_clamped = DT_MIN;
        end else if (i_item.period_us > PeriodW'(DT_MAX)) begin
            dt_clamped = DT_MAX;
        end else begin
            dt_clamped = i_item.period_us[DtW-1:0];
        end
        act_age = r_time - r_act;
        tgt_age = r_time - r_ttime;
    end

    always_comb begin
        o_stat.is_tick   = r_is_tick;
        o_stat.armed     = r_armed;
        o_stat.in_hold   = act_age < {6'd0, r_hold};
        o_stat.fresh     = r_present && (tgt_age <= {8'd0, r_watchdog});
        o_stat.gt        = r_s > {2'b00, r_p};
        o_stat.div_done  = (r_dcnt == '0);
        o_stat.sqrt_done = (r_scnt == '0);
    end

    assign o_status = r_out_status;
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            o_cmd_vel[i] = r_out[i];
        end
    end

    // Control state, configuration and the command vector.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= RST_HOLD;
            r_watchdog  <= RST_WATCHDOG;
            r_lin_speed <= RST_LIN_SPEED;
            r_lin_accel <= RST_LIN_ACCEL;
            r_ang_speed <= RST_ANG_SPEED;
            r_ang_accel <= RST_ANG_ACCEL;
            r_armed     <= 1'b0;
            r_present   <= 1'b0;
            r_act       <= '0;
            r_ttime     <= '0;
            r_dcnt      <= '0;
            r_scnt      <= '0;
            for (int i = 0; i < 6; i++) begin
                r_cmd[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HOLD:      r_hold      <= i_cfg_data;
                    CFG_WATCHDOG:  r_watchdog  <= i_cfg_data[23:0];
                    CFG_LIN_SPEED: r_lin_speed <= i_cfg_data[LimW-1:0];
                    CFG_LIN_ACCEL: r_lin_accel <= i_cfg_data[LimW-1:0];
                    CFG_ANG_SPEED: r_ang_speed <= i_cfg_data[LimW-1:0];
                    CFG_ANG_ACCEL: r_ang_accel <= i_cfg_data[LimW-1:0];
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_CAPTURE: begin
                    if (i_item.func == FUNC_TARGET) begin
                        r_present <= 1'b1;
                        r_ttime   <= i_item.time_us;
                    end
                end
                OP_ARM: begin
                    r_armed <= 1'b1;
                    r_act   <= r_time;
                    for (int i = 0; i < 6; i++) r_cmd[i] <= '0;
                end
                OP_ZERO: begin
                    for (int i = 0; i < 6; i++) r_cmd[i] <= '0;
                end
                OP_DROP: begin
                    r_present <= 1'b0;
                    for (int i = 0; i < 6; i++) r_cmd[i] <= '0;
                end
                OP_DIV_LD_SC: r_dcnt <= 6'(ProdW);
                OP_DIV_ITER:  r_dcnt <= r_dcnt - 6'd1;
                OP_SQRT_LD:   r_scnt <= 5'(RootW);
                OP_SQRT_ITER: r_scnt <= r_scnt - 5'd1;
                OP_ADD_CMD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_cmd[i_cmd.k ? 3'(i + 3) : 3'(i)] <=
                            r_cmd[i_cmd.k ? 3'(i + 3) : 3'(i)] + r_v[i][VelW-1:0];
                    end
                end
                OP_STORE_CMD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_cmd[i_cmd.k ? 3'(i + 3) : 3'(i)] <= r_v[i][VelW-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload and arithmetic registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_is_tick <= i_item.func;
                r_time    <= i_item.time_us;
                r_dt      <= dt_clamped;
                if (i_item.func == FUNC_TARGET) begin
                    r_tgt[0] <= i_item.lin_x;
                    r_tgt[1] <= i_item.lin_y;
                    r_tgt[2] <= i_item.lin_z;
                    r_tgt[3] <= i_item.ang_x;
                    r_tgt[4] <= i_item.ang_y;
                    r_tgt[5] <= i_item.ang_z;
                end
            end
            OP_MUL_STEP, OP_MUL_SQ, OP_MUL_LL, OP_MUL_SC: r_p <= mul_a * mul_b;
            // Rounded product with the factor 2^6 of one million shifted out.
            OP_DIV_LD_STEP: r_dnum <= (r_p + ProdW'(STEP_ROUND)) >> STEP_PRE;
            OP_DIV_LD_SC: begin
                r_dnum <= r_p;
                r_dden <= root_ceil;
                r_drem <= '0;
            end
            OP_DIV_ITER: begin
                r_dnum <= {r_dnum[ProdW-2:0], d_ge};
                r_drem <= d_ge ? d_diff[RootW-1:0] : d_t[RootW-1:0];
            end
            OP_LIM_STEP: r_lim <= LimW'(step_prod[62:STEP_SHIFT]);
            OP_LOAD_DELTA: begin
                for (int i = 0; i < 3; i++) begin
                    r_v[i] <= {r_tgt[i_cmd.k ? 3'(i + 3) : 3'(i)][VelW-1],
                               r_tgt[i_cmd.k ? 3'(i + 3) : 3'(i)]}
                            - {r_cmd[i_cmd.k ? 3'(i + 3) : 3'(i)][VelW-1],
                               r_cmd[i_cmd.k ? 3'(i + 3) : 3'(i)]};
                end
                r_s <= '0;
            end
            OP_LOAD_CMD: begin
                for (int i = 0; i < 3; i++) begin
                    r_v[i] <= {r_cmd[i_cmd.k ? 3'(i + 3) : 3'(i)][VelW-1],
                               r_cmd[i_cmd.k ? 3'(i + 3) : 3'(i)]};
                end
                r_s   <= '0;
                r_lim <= speed_k;
            end
            OP_ACC: r_s <= r_s + {2'b00, r_p};
            OP_SQRT_LD: begin
                r_sx   <= r_s;
                r_root <= '0;
                r_srem <= '0;
            end
            OP_SQRT_ITER: begin
                r_sx   <= {r_sx[SumW-3:0], 2'b00};
                r_root <= {r_root[RootW-2:0], s_ge};
                r_srem <= s_ge ? s_diff[RootW:0] : s_t[RootW:0];
            end
            OP_WR_SC: begin
                r_v[i_cmd.idx] <= vsel[VelW] ? -{1'b0, q24} : {1'b0, q24};
            end
            OP_OUT: begin
                r_out_status <= i_cmd.status;
                for (int i = 0; i < 6; i++) r_out[i] <= r_cmd[i];
            end
            default: ;
        endcase
    end

endmodule

// File: hw/rtl/twist_slew_and_speed_limiter.sv
// Top level of the twist slew and speed limiter.
// A target transaction is taken and gives no result.
// An arming, hold or stale tick goes from its decision straight to its result.
// A tracking tick gives its result once the one-bit-per-cycle shared divider (up to 12 divisions
// per tick) and the 25-step root unit are through.
// Synchronous active-low reset clears the configuration to defaults and the command to zero.
module twist_slew_and_speed_limiter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [25:0] i_cfg_data,
    twsl_in_if.sink     i_in,
    twsl_out_if.source  o_out
);
    import twsl_pkg::*;

    t_cmd               cmd;
    t_stat              stat;
    t_in_item           item;
    logic signed [23:0] cmd_vel [6];
    logic [1:0]         status;

    // Input payload gathered for the datapath.
    always_comb begin
        item.func      = i_in.func;
        item.time_us   = i_in.time_us;
        item.period_us = i_in.period_us;
        item.lin_x     = i_in.lin_x;
        item.lin_y     = i_in.lin_y;
        item.lin_z     = i_in.lin_z;
        item.ang_x     = i_in.ang_x;
        item.ang_y     = i_in.ang_y;
        item.ang_z     = i_in.ang_z;
    end

    twsl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    twsl_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_status   (status),
        .o_cmd_vel  (cmd_vel)
    );

    // Result payload.
    assign o_out.status    = status;
    assign o_out.cmd_lin_x = cmd_vel[0];
    assign o_out.cmd_lin_y = cmd_vel[1];
    assign o_out.cmd_lin_z = cmd_vel[2];
    assign o_out.cmd_ang_x = cmd_vel[3];
    assign o_out.cmd_ang_y = cmd_vel[4];
    assign o_out.cmd_ang_z = cmd_vel[5];

endmodule
